// ===== sv/bfdc_pkg.sv =====
// shared types, constants and codes of the bottle fill dispense controller
package bfdc_pkg;

  // field widths
  localparam int unsigned WEIGHT_W   = 14;
  localparam int unsigned GRAMS_W    = 13;
  localparam int unsigned VOLUME_W   = 12;
  localparam int unsigned STEP_W     = 10;
  localparam int unsigned GRAM8_W    = 8;
  localparam int unsigned TOTAL_W    = 20;
  localparam int unsigned DAY_W      = 5;
  localparam int unsigned LEDBAR_W   = 10;
  localparam int unsigned LIT_MAX_W  = 5;

  // apb port
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 5;
  localparam int unsigned CFG_IDX_W  = 3;

  // default led count
  localparam int unsigned LED_COUNT_DEF = 10;

  // register reset values
  localparam logic [STEP_W-1:0]   VOLUME_STEP_RST        = 10'd50;
  localparam logic [VOLUME_W-1:0] VOLUME_MAX_RST         = 12'd1000;
  localparam logic [VOLUME_W-1:0] VOLUME_DEFAULT_RST     = 12'd50;
  localparam logic [GRAM8_W-1:0]  BOTTLE_PRESENT_MIN_RST = 8'd10;
  localparam logic [GRAM8_W-1:0]  LIGHT_BOTTLE_LIMIT_RST = 8'd30;
  localparam logic [GRAM8_W-1:0]  PLASTIC_ALLOWANCE_RST  = 8'd15;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_VOLUME_STEP        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VOLUME_MAX         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VOLUME_DEFAULT     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BOTTLE_PRESENT_MIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_BOTTLE_LIMIT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PLASTIC_ALLOWANCE  = 3'd5;

  typedef enum logic [2:0] {
    FM_SELECT = 3'd0,
    FM_READY  = 3'd1,
    FM_POUR   = 3'd2,
    FM_PAUSE  = 3'd3,
    FM_FULL   = 3'd4
  } fill_mode_e;

  typedef enum logic [1:0] {
    NT_NONE         = 2'd0,
    NT_OVER_MAX     = 2'd1,
    NT_NO_BOTTLE    = 2'd2,
    NT_ALREADY_FULL = 2'd3
  } notice_e;

  typedef struct packed {
    logic [STEP_W-1:0]   volume_step;
    logic [VOLUME_W-1:0] volume_max;
    logic [VOLUME_W-1:0] volume_default;
    logic [GRAM8_W-1:0]  bottle_present_min;
    logic [GRAM8_W-1:0]  light_bottle_limit;
    logic [GRAM8_W-1:0]  plastic_allowance;
  } cfg_t;

  // request to the led bar divider
  typedef struct packed {
    logic                start;
    logic [GRAMS_W-1:0]  poured;
    logic [VOLUME_W-1:0] target;
  } div_req_t;

endpackage

// ===== sv/bfdc_if.sv =====
// stream interfaces for control pass items and their results
interface bfdc_in_if;
  logic              valid;
  logic              ready;
  logic              weight_valid;
  logic signed [13:0] weight;
  logic              start_press;
  logic              mode_press;
  logic              date_valid;
  logic [4:0]        day_of_month;

  modport source (
    output valid, weight_valid, weight, start_press, mode_press, date_valid, day_of_month,
    input  ready
  );
  modport sink (
    input  valid, weight_valid, weight, start_press, mode_press, date_valid, day_of_month,
    output ready
  );
endinterface

interface bfdc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic        pump_on;
  logic [9:0]  led_bar;
  logic [11:0] selected_volume;
  logic [11:0] target_amount;
  logic [12:0] poured_amount;
  logic [19:0] daily_total;
  logic [19:0] daily_total_shown;
  logic        display_mode;
  logic [1:0]  notice;

  modport source (
    output valid, mode, pump_on, led_bar, selected_volume, target_amount, poured_amount,
           daily_total, daily_total_shown, display_mode, notice,
    input  ready
  );
  modport sink (
    input  valid, mode, pump_on, led_bar, selected_volume, target_amount, poured_amount,
           daily_total, daily_total_shown, display_mode, notice,
    output ready
  );
endinterface

// ===== sv/bfdc_cfg_regs.sv =====
// apb configuration register file
module bfdc_cfg_regs (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [bfdc_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [bfdc_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [bfdc_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                 pready,
  output bfdc_pkg::cfg_t                       cfg_o
);
  import bfdc_pkg::*;

  cfg_t                 cfg_q, cfg_d;
  logic [CFG_IDX_W-1:0] idx;
  logic                 wr_en;

  assign idx    = paddr[APB_ADDR_W-1:2];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        CFG_VOLUME_STEP:        cfg_d.volume_step        = pwdata[STEP_W-1:0];
        CFG_VOLUME_MAX:         cfg_d.volume_max         = pwdata[VOLUME_W-1:0];
        CFG_VOLUME_DEFAULT:     cfg_d.volume_default     = pwdata[VOLUME_W-1:0];
        CFG_BOTTLE_PRESENT_MIN: cfg_d.bottle_present_min = pwdata[GRAM8_W-1:0];
        CFG_LIGHT_BOTTLE_LIMIT: cfg_d.light_bottle_limit = pwdata[GRAM8_W-1:0];
        CFG_PLASTIC_ALLOWANCE:  cfg_d.plastic_allowance  = pwdata[GRAM8_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      CFG_VOLUME_STEP:        prdata = APB_DATA_W'(cfg_q.volume_step);
      CFG_VOLUME_MAX:         prdata = APB_DATA_W'(cfg_q.volume_max);
      CFG_VOLUME_DEFAULT:     prdata = APB_DATA_W'(cfg_q.volume_default);
      CFG_BOTTLE_PRESENT_MIN: prdata = APB_DATA_W'(cfg_q.bottle_present_min);
      CFG_LIGHT_BOTTLE_LIMIT: prdata = APB_DATA_W'(cfg_q.light_bottle_limit);
      CFG_PLASTIC_ALLOWANCE:  prdata = APB_DATA_W'(cfg_q.plastic_allowance);
      default:                prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.volume_step        <= VOLUME_STEP_RST;
      cfg_q.volume_max         <= VOLUME_MAX_RST;
      cfg_q.volume_default     <= VOLUME_DEFAULT_RST;
      cfg_q.bottle_present_min <= BOTTLE_PRESENT_MIN_RST;
      cfg_q.light_bottle_limit <= LIGHT_BOTTLE_LIMIT_RST;
      cfg_q.plastic_allowance  <= PLASTIC_ALLOWANCE_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== sv/bfdc_led_div.sv =====
// iterative divider for the progress bar: counts how many target steps fit
module bfdc_led_div #(
  parameter int unsigned LED_COUNT = bfdc_pkg::LED_COUNT_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  bfdc_pkg::div_req_t               req_i,
  output logic                             done_o,
  output logic [$clog2(LED_COUNT+1)-1:0]   lit_o
);
  import bfdc_pkg::*;

  localparam int unsigned LIT_W = $clog2(LED_COUNT + 1);
  localparam int unsigned NUM_W = GRAMS_W + LIT_W;
  localparam int unsigned ACC_W = NUM_W + 1;

  logic                busy_q, busy_d;
  logic [NUM_W-1:0]    num_q, num_d;
  logic [ACC_W-1:0]    acc_q, acc_d;
  logic [VOLUME_W-1:0] den_q, den_d;
  logic [LIT_W-1:0]    cnt_q, cnt_d;
  logic                step;

  // one more led fits while k*target <= poured*LED_COUNT, capped at the led count
  assign step   = ({1'b0, num_q} >= acc_q) && (cnt_q < LIT_W'(LED_COUNT));
  assign done_o = busy_q & ~step;
  assign lit_o  = cnt_q;

  always_comb begin
    busy_d = busy_q;
    num_d  = num_q;
    acc_d  = acc_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      num_d  = NUM_W'(req_i.poured * LED_COUNT);
      acc_d  = ACC_W'(req_i.target);
      den_d  = req_i.target;
      cnt_d  = '0;
    end else if (busy_q) begin
      if (step) begin
        cnt_d = cnt_q + 1'b1;
        acc_d = acc_q + ACC_W'(den_q);
      end else begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    acc_q <= acc_d;
    den_q <= den_d;
  end

endmodule

// ===== sv/bottle_fill_dispense_controller_core.sv =====
// bottle fill dispense controller: control pass sequencer, led divider and registers
// sequence: the item is latched in ST_IDLE, then ST_PASS, ST_POUR and ST_LED run in order,
//   ST_WAIT while the led divider runs, and ST_DONE loads the result register once it is free
// throughput: one item at a time, the next transfer is taken after the result is loaded
// reset: asynchronous active low, clears mode and totals, loads register defaults, no result pending
module bottle_fill_dispense_controller_core #(
  parameter int unsigned LED_COUNT = bfdc_pkg::LED_COUNT_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  bfdc_in_if.sink                         in_i,
  bfdc_out_if.source                      out_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [bfdc_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [bfdc_pkg::APB_DATA_W-1:0] pwdata,
  output logic [bfdc_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);
  import bfdc_pkg::*;

  localparam int unsigned LIT_W = $clog2(LED_COUNT + 1);

  // sequencer states
  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_PASS = 6'b000010,
    ST_POUR = 6'b000100,
    ST_LED  = 6'b001000,
    ST_WAIT = 6'b010000,
    ST_DONE = 6'b100000
  } seq_state_e;

  // turn a led count into a bar pattern, bits above the count stay dark
  function automatic logic [LEDBAR_W-1:0] led_bar_of(input logic [LIT_MAX_W-1:0] lit);
    logic [LEDBAR_W-1:0] bar;
    for (int i = 0; i < LEDBAR_W; i++) begin
      bar[i] = (LIT_MAX_W'(i) < lit);
    end
    return bar;
  endfunction

  cfg_t                 cfg;
  div_req_t             div_req;
  logic                 div_done;
  logic [LIT_W-1:0]     div_lit;

  seq_state_e           state_q, state_d;

  // latched input item
  logic                 lat_wv_q, lat_wv_d;
  logic [WEIGHT_W-1:0]  lat_w_q, lat_w_d;
  logic                 lat_start_q, lat_start_d;
  logic                 lat_mode_q, lat_mode_d;
  logic                 lat_dv_q, lat_dv_d;
  logic [DAY_W-1:0]     lat_day_q, lat_day_d;

  // controller state
  fill_mode_e           fm_q, fm_d;
  logic [VOLUME_W-1:0]  chosen_q, chosen_d;
  logic [GRAMS_W-1:0]   last_weight_q, last_weight_d;
  logic [GRAMS_W-1:0]   start_weight_q, start_weight_d;
  logic [VOLUME_W-1:0]  target_q, target_d;
  logic [GRAMS_W-1:0]   poured_q, poured_d;
  logic [TOTAL_W-1:0]   day_total_q, day_total_d;
  logic [DAY_W-1:0]     last_day_q, last_day_d;
  logic                 page_q, page_d;
  logic                 pend_q, pend_d;
  logic [LEDBAR_W-1:0]  led_q, led_d;
  notice_e              notice_q, notice_d;

  // result register
  logic                 out_valid_q, out_valid_d;
  logic [2:0]           out_mode_q, out_mode_d;
  logic                 out_pump_q, out_pump_d;
  logic [LEDBAR_W-1:0]  out_led_q, out_led_d;
  logic [VOLUME_W-1:0]  out_sel_q, out_sel_d;
  logic [VOLUME_W-1:0]  out_tgt_q, out_tgt_d;
  logic [GRAMS_W-1:0]   out_poured_q, out_poured_d;
  logic [TOTAL_W-1:0]   out_total_q, out_total_d;
  logic [TOTAL_W-1:0]   out_shown_q, out_shown_d;
  logic                 out_page_q, out_page_d;
  logic [1:0]           out_notice_q, out_notice_d;

  bfdc_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  bfdc_led_div #(
    .LED_COUNT (LED_COUNT)
  ) u_led_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .lit_o  (div_lit)
  );

  // new item only when the sequencer is idle; a waiting result holds it in its last state
  assign in_i.ready = (state_q == ST_IDLE);

  assign out_o.valid             = out_valid_q;
  assign out_o.mode              = out_mode_q;
  assign out_o.pump_on           = out_pump_q;
  assign out_o.led_bar           = out_led_q;
  assign out_o.selected_volume   = out_sel_q;
  assign out_o.target_amount     = out_tgt_q;
  assign out_o.poured_amount     = out_poured_q;
  assign out_o.daily_total       = out_total_q;
  assign out_o.daily_total_shown = out_shown_q;
  assign out_o.display_mode      = out_page_q;
  assign out_o.notice            = out_notice_q;

  always_comb begin
    logic                mode_ev;
    logic                early;
    logic [GRAMS_W-1:0]  lw;
    logic [GRAMS_W-1:0]  plastic;
    logic [GRAMS_W-1:0]  existing;
    logic [VOLUME_W:0]   vol_sum;
    logic [GRAMS_W-1:0]  pour_v;
    logic [TOTAL_W:0]    sum_v;
    fill_mode_e          fm_v;

    state_d        = state_q;
    lat_wv_d       = lat_wv_q;
    lat_w_d        = lat_w_q;
    lat_start_d    = lat_start_q;
    lat_mode_d     = lat_mode_q;
    lat_dv_d       = lat_dv_q;
    lat_day_d      = lat_day_q;
    fm_d           = fm_q;
    chosen_d       = chosen_q;
    last_weight_d  = last_weight_q;
    start_weight_d = start_weight_q;
    target_d       = target_q;
    poured_d       = poured_q;
    day_total_d    = day_total_q;
    last_day_d     = last_day_q;
    page_d         = page_q;
    pend_d         = pend_q;
    led_d          = led_q;
    notice_d       = notice_q;

    out_valid_d    = out_valid_q;
    out_mode_d     = out_mode_q;
    out_pump_d     = out_pump_q;
    out_led_d      = out_led_q;
    out_sel_d      = out_sel_q;
    out_tgt_d      = out_tgt_q;
    out_poured_d   = out_poured_q;
    out_total_d    = out_total_q;
    out_shown_d    = out_shown_q;
    out_page_d     = out_page_q;
    out_notice_d   = out_notice_q;

    div_req.start  = 1'b0;
    div_req.poured = poured_q;
    div_req.target = target_q;

    // default decode of the latched item
    mode_ev  = lat_mode_q | pend_q;
    early    = 1'b0;
    lw       = lat_wv_q ? (lat_w_q[WEIGHT_W-1] ? '0 : lat_w_q[GRAMS_W-1:0]) : last_weight_q;
    // bottle tare: light bottles count fully as plastic
    plastic  = (lw < GRAMS_W'(cfg.light_bottle_limit)) ? lw
                                                        : GRAMS_W'(cfg.plastic_allowance);
    existing = (lw > plastic) ? (lw - plastic) : '0;
    vol_sum  = (VOLUME_W + 1)'(chosen_q) + (VOLUME_W + 1)'(cfg.volume_step);
    pour_v   = (last_weight_q > start_weight_q) ? (last_weight_q - start_weight_q) : '0;
    sum_v    = '0;
    fm_v     = fm_q;

    // the result register drains on its own transfer
    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          lat_wv_d    = in_i.weight_valid;
          lat_w_d     = in_i.weight;
          lat_start_d = in_i.start_press;
          lat_mode_d  = in_i.mode_press;
          lat_dv_d    = in_i.date_valid;
          lat_day_d   = in_i.day_of_month;
          state_d     = ST_PASS;
        end
      end

      // day change, scale reading, buttons
      ST_PASS: begin
        pend_d   = 1'b0;
        notice_d = NT_NONE;
        if (lat_dv_q && (lat_day_q != '0) && (lat_day_q != last_day_q)) begin
          day_total_d = '0;
          last_day_d  = lat_day_q;
        end
        last_weight_d = lw;
        if (lat_start_q) begin
          case (fm_q)
            FM_SELECT: begin
              // raise volume, wrap to default above max
              if (vol_sum > (VOLUME_W + 1)'(cfg.volume_max)) begin
                chosen_d = cfg.volume_default;
                notice_d = NT_OVER_MAX;
              end else begin
                chosen_d = vol_sum[VOLUME_W-1:0];
              end
            end
            FM_READY: begin
              if (lw < GRAMS_W'(cfg.bottle_present_min)) begin
                notice_d = NT_NO_BOTTLE;
              end else begin
                start_weight_d = lw;
                if (GRAMS_W'(chosen_q) <= existing) begin
                  // bottle already full: hold a mode press for the next pass
                  early    = 1'b1;
                  notice_d = NT_ALREADY_FULL;
                  pend_d   = mode_ev;
                end else begin
                  target_d = chosen_q - existing[VOLUME_W-1:0];
                  fm_v     = FM_POUR;
                end
              end
            end
            FM_POUR:  fm_v = FM_PAUSE;
            FM_PAUSE: fm_v = FM_POUR;
            default: ;
          endcase
        end
        if (early) begin
          state_d = ST_DONE;
        end else begin
          if (mode_ev) begin
            if (fm_v == FM_SELECT) begin
              fm_v = FM_READY;
            end else begin
              page_d = ~page_q;
            end
          end
          state_d = ST_POUR;
        end
        fm_d = fm_v;
      end

      // pour progress, completion and bottle removal
      ST_POUR: begin
        if (fm_q == FM_POUR) begin
          poured_d = pour_v;
          if (pour_v >= GRAMS_W'(target_q)) begin
            fm_v        = FM_FULL;
            sum_v       = (TOTAL_W + 1)'(day_total_q) + (TOTAL_W + 1)'(target_q);
            day_total_d = sum_v[TOTAL_W] ? '1 : sum_v[TOTAL_W-1:0];
            led_d       = led_bar_of(LIT_MAX_W'(LED_COUNT));
          end
        end
        if ((fm_v == FM_FULL) && (last_weight_q < GRAMS_W'(cfg.bottle_present_min))) begin
          poured_d       = '0;
          start_weight_d = '0;
          target_d       = '0;
          fm_v           = FM_SELECT;
          chosen_d       = cfg.volume_default;
          led_d          = '0;
        end
        fm_d    = fm_v;
        state_d = ST_LED;
      end

      // progress bar only while a fill is running with something poured
      ST_LED: begin
        if (((fm_q == FM_POUR) || (fm_q == FM_PAUSE)) && (poured_q != '0) &&
            (target_q != '0)) begin
          div_req.start = 1'b1;
          state_d       = ST_WAIT;
        end else begin
          state_d = ST_DONE;
        end
      end

      ST_WAIT: begin
        if (div_done) begin
          led_d   = led_bar_of(LIT_MAX_W'(div_lit));
          state_d = ST_DONE;
        end
      end

      // load the result register once it is free
      ST_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d  = 1'b1;
          out_mode_d   = fm_q;
          out_pump_d   = (fm_q == FM_POUR);
          out_led_d    = led_q;
          out_sel_d    = chosen_q;
          out_tgt_d    = target_q;
          out_poured_d = poured_q;
          out_total_d  = day_total_q;
          out_page_d   = page_q;
          out_notice_d = notice_q;
          if ((fm_q == FM_POUR) || (fm_q == FM_PAUSE)) begin
            sum_v       = (TOTAL_W + 1)'(day_total_q) + (TOTAL_W + 1)'(poured_q);
            out_shown_d = sum_v[TOTAL_W] ? '1 : sum_v[TOTAL_W-1:0];
          end else begin
            out_shown_d = day_total_q;
          end
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      fm_q           <= FM_SELECT;
      chosen_q       <= VOLUME_DEFAULT_RST;
      last_weight_q  <= '0;
      start_weight_q <= '0;
      target_q       <= '0;
      poured_q       <= '0;
      day_total_q    <= '0;
      last_day_q     <= '0;
      page_q         <= 1'b0;
      pend_q         <= 1'b0;
      led_q          <= '0;
      notice_q       <= NT_NONE;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      fm_q           <= fm_d;
      chosen_q       <= chosen_d;
      last_weight_q  <= last_weight_d;
      start_weight_q <= start_weight_d;
      target_q       <= target_d;
      poured_q       <= poured_d;
      day_total_q    <= day_total_d;
      last_day_q     <= last_day_d;
      page_q         <= page_d;
      pend_q         <= pend_d;
      led_q          <= led_d;
      notice_q       <= notice_d;
      out_valid_q    <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    lat_wv_q     <= lat_wv_d;
    lat_w_q      <= lat_w_d;
    lat_start_q  <= lat_start_d;
    lat_mode_q   <= lat_mode_d;
    lat_dv_q     <= lat_dv_d;
    lat_day_q    <= lat_day_d;
    out_mode_q   <= out_mode_d;
    out_pump_q   <= out_pump_d;
    out_led_q    <= out_led_d;
    out_sel_q    <= out_sel_d;
    out_tgt_q    <= out_tgt_d;
    out_poured_q <= out_poured_d;
    out_total_q  <= out_total_d;
    out_shown_q  <= out_shown_d;
    out_page_q   <= out_page_d;
    out_notice_q <= out_notice_d;
  end

endmodule

// ===== bench/tb_bottle_fill_dispense_controller_core.sv =====
// self-checking bench for the bottle fill dispense controller with a per-pass fill predictor
`timescale 1ns / 100ps

module tb_bottle_fill_dispense_controller_core;
  import bfdc_pkg::*;

  localparam int unsigned LED_N       = LED_COUNT_DEF;
  localparam int unsigned CYCLE_LIMIT = 400000;  // far above the slowest legal run
  localparam int unsigned SETTLE      = 40;      // above the worst item latency
  localparam int unsigned RX_HOLD_LEN = 400;     // long receiver hold-off
  localparam int unsigned PHASE_ITEMS = 130;

  // one control pass as offered to the block
  typedef struct packed {
    logic               weight_valid;
    logic signed [13:0] weight;
    logic               start_press;
    logic               mode_press;
    logic               date_valid;
    logic [4:0]         day_of_month;
  } pass_item_t;

  // one pass result as seen on the output channel
  typedef struct packed {
    fill_mode_e  mode;
    logic        pump_on;
    logic [9:0]  led_bar;
    logic [11:0] selected_volume;
    logic [11:0] target_amount;
    logic [12:0] poured_amount;
    logic [19:0] daily_total;
    logic [19:0] daily_total_shown;
    logic        display_mode;
    notice_e     notice;
  } pass_result_t;

  logic clk_i;
  logic rst_ni;

  // apb side
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  bfdc_in_if  pass_in ();
  bfdc_out_if pass_out ();

  bottle_fill_dispense_controller_core #(
    .LED_COUNT(LED_N)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (pass_in),
    .out_o   (pass_out),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // stimulus and scoreboard storage
  pass_item_t   pass_queue[$];      // items waiting to be offered
  pass_result_t expected_fill[$];   // predicted results, oldest first
  pass_item_t   offered_pass;       // item currently on the input channel
  pass_result_t got_result;
  pass_result_t want_result;
  logic         item_taken;         // input transfer at the last rising edge

  int unsigned  error_count;
  int unsigned  cycle_count;
  int unsigned  phase_items;
  int unsigned  tx_gap;
  int unsigned  rx_gap;
  int unsigned  rx_hold_cnt;
  bit           rx_hold_req;
  bit           rx_hold_done;
  bit           idle_en;
  logic [4:0]   gen_day;

  // predictor copy of the registers and state
  cfg_t         cfg_shadow;
  fill_mode_e   mode_q;
  logic [11:0]  volume_sel;
  logic [12:0]  weight_hold;
  logic [12:0]  weight_at_start;
  logic [11:0]  target_ml;
  logic [12:0]  poured_g;
  logic [19:0]  total_day;
  logic [4:0]   day_seen;
  logic         page_alt;
  logic         mode_held;
  logic [9:0]   bar_leds;

  // 2 ns clock
  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  task automatic reset_model();
    cfg_shadow.volume_step        = VOLUME_STEP_RST;
    cfg_shadow.volume_max         = VOLUME_MAX_RST;
    cfg_shadow.volume_default     = VOLUME_DEFAULT_RST;
    cfg_shadow.bottle_present_min = BOTTLE_PRESENT_MIN_RST;
    cfg_shadow.light_bottle_limit = LIGHT_BOTTLE_LIMIT_RST;
    cfg_shadow.plastic_allowance  = PLASTIC_ALLOWANCE_RST;
    mode_q          = FM_SELECT;
    volume_sel      = VOLUME_DEFAULT_RST;
    weight_hold     = '0;
    weight_at_start = '0;
    target_ml       = '0;
    poured_g        = '0;
    total_day       = '0;
    day_seen        = '0;
    page_alt        = 1'b0;
    mode_held       = 1'b0;
    bar_leds        = '0;
  endtask

  // advances the predictor by one control pass and returns the expected result
  function automatic pass_result_t dispense_pass(input pass_item_t it);
    notice_e      nt;
    logic         mode_ev;
    logic         skip_rest;
    logic [12:0]  plastic;
    logic [12:0]  existing;
    int unsigned  vol_sum;
    int unsigned  acc;
    int unsigned  lit;
    int unsigned  cap;
    pass_result_t r;
    nt        = NT_NONE;
    skip_rest = 1'b0;
    cap       = (LED_N > 16) ? 16 : LED_N;
    mode_ev   = it.mode_press | mode_held;
    mode_held = 1'b0;

    // a plausible new day clears the daily total, day zero never counts
    if (it.date_valid && it.day_of_month != 0 && it.day_of_month != day_seen) begin
      total_day = '0;
      day_seen  = it.day_of_month;
    end

    // negative readings clamp to zero, no reading keeps the last one
    if (it.weight_valid) begin
      weight_hold = it.weight[13] ? '0 : it.weight[12:0];
    end

    if (it.start_press) begin
      case (mode_q)
        FM_SELECT: begin
          vol_sum = 32'(volume_sel) + 32'(cfg_shadow.volume_step);
          if (vol_sum > cfg_shadow.volume_max) begin
            volume_sel = cfg_shadow.volume_default;
            nt         = NT_OVER_MAX;
          end else begin
            volume_sel = vol_sum[11:0];
          end
        end
        FM_READY: begin
          if (weight_hold < cfg_shadow.bottle_present_min) begin
            nt = NT_NO_BOTTLE;
          end else begin
            weight_at_start = weight_hold;
            // a light bottle is all plastic, a heavier one gets the fixed allowance
            plastic  = (weight_at_start < cfg_shadow.light_bottle_limit) ?
                       weight_at_start : 13'(cfg_shadow.plastic_allowance);
            existing = (weight_at_start > plastic) ? weight_at_start - plastic : '0;
            if (volume_sel <= existing) begin
              // bottle already full: mode press waits for the next pass
              mode_held = mode_ev;
              nt        = NT_ALREADY_FULL;
              skip_rest = 1'b1;
            end else begin
              target_ml = 12'(13'(volume_sel) - existing);
              mode_q    = FM_POUR;
            end
          end
        end
        FM_POUR:  mode_q = FM_PAUSE;
        FM_PAUSE: mode_q = FM_POUR;
        default: ;
      endcase
    end

    if (!skip_rest) begin
      if (mode_ev) begin
        if (mode_q == FM_SELECT) mode_q = FM_READY;
        else page_alt = ~page_alt;
      end

      if (mode_q == FM_POUR) begin
        poured_g = (weight_hold > weight_at_start) ? weight_hold - weight_at_start : '0;
        if (poured_g >= target_ml) begin
          mode_q = FM_FULL;
          acc    = 32'(total_day) + 32'(target_ml);
          total_day = (acc > 32'hFFFFF) ? 20'hFFFFF : acc[19:0];
          bar_leds  = 10'((32'd1 << cap) - 32'd1);
        end
      end

      // bottle lifted off after a fill
      if (mode_q == FM_FULL && weight_hold < cfg_shadow.bottle_present_min) begin
        poured_g        = '0;
        weight_at_start = '0;
        target_ml       = '0;
        mode_q          = FM_SELECT;
        volume_sel      = cfg_shadow.volume_default;
        bar_leds        = '0;
      end

      // progress bar only moves while pouring or paused with something to show
      if ((mode_q == FM_POUR || mode_q == FM_PAUSE) && poured_g != 0 && target_ml != 0) begin
        lit = (32'(poured_g) * LED_N) / 32'(target_ml);
        if (lit > cap) lit = cap;
        bar_leds = 10'((32'd1 << lit) - 32'd1);
      end
    end

    acc = 32'(total_day);
    if (mode_q == FM_POUR || mode_q == FM_PAUSE) begin
      acc = acc + 32'(poured_g);
      if (acc > 32'hFFFFF) acc = 32'hFFFFF;
    end
    r.mode              = mode_q;
    r.pump_on           = (mode_q == FM_POUR);
    r.led_bar           = bar_leds;
    r.selected_volume   = volume_sel;
    r.target_amount     = target_ml;
    r.poured_amount     = poured_g;
    r.daily_total       = total_day;
    r.daily_total_shown = acc[19:0];
    r.display_mode      = page_alt;
    r.notice            = nt;
    return r;
  endfunction

  function automatic string fmt_result(input pass_result_t r);
    return $sformatf("mode=%0d pump=%0b led=%h sel=%0d tgt=%0d poured=%0d total=%0d shown=%0d page=%0b notice=%0d",
                     r.mode, r.pump_on, r.led_bar, r.selected_volume, r.target_amount,
                     r.poured_amount, r.daily_total, r.daily_total_shown, r.display_mode,
                     r.notice);
  endfunction

  task automatic flag_error(input string msg);
    error_count++;
    if (error_count <= 10) $display("%s", msg);
  endtask

  // gap length: mostly none or short, now and then long
  function automatic int unsigned next_gap();
    int unsigned r;
    if (!idle_en) return 0;
    r = $urandom_range(99, 0);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 25);
  endfunction

  // ---------------------------------------------------------------------------
  // input driver: changes on the falling edge, holds an item until its transfer
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!(pass_in.valid && !item_taken)) begin
        if (tx_gap > 0) begin
          tx_gap--;
          pass_in.valid <= 1'b0;
        end else if (pass_queue.size() > 0) begin
          offered_pass = pass_queue.pop_front();
          pass_in.weight_valid <= offered_pass.weight_valid;
          pass_in.weight       <= offered_pass.weight;
          pass_in.start_press  <= offered_pass.start_press;
          pass_in.mode_press   <= offered_pass.mode_press;
          pass_in.date_valid   <= offered_pass.date_valid;
          pass_in.day_of_month <= offered_pass.day_of_month;
          pass_in.valid        <= 1'b1;
          tx_gap = next_gap();
        end else begin
          pass_in.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result receiver: random ready, plus one long hold-off counted here
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (rx_hold_req && !rx_hold_done) begin
        pass_out.ready <= 1'b0;
        rx_hold_cnt++;
        if (rx_hold_cnt >= RX_HOLD_LEN) rx_hold_done = 1'b1;
      end else if (rx_gap > 0) begin
        rx_gap--;
        pass_out.ready <= 1'b0;
      end else begin
        pass_out.ready <= 1'b1;
        rx_gap = next_gap();
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: samples both channels on the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      cycle_count++;
      // result transfer, checked against the oldest prediction
      if (pass_out.valid && pass_out.ready) begin
        got_result.mode              = fill_mode_e'(pass_out.mode);
        got_result.pump_on           = pass_out.pump_on;
        got_result.led_bar           = pass_out.led_bar;
        got_result.selected_volume   = pass_out.selected_volume;
        got_result.target_amount     = pass_out.target_amount;
        got_result.poured_amount     = pass_out.poured_amount;
        got_result.daily_total       = pass_out.daily_total;
        got_result.daily_total_shown = pass_out.daily_total_shown;
        got_result.display_mode      = pass_out.display_mode;
        got_result.notice            = notice_e'(pass_out.notice);
        if (expected_fill.size() == 0) begin
          flag_error($sformatf("unexpected result: %s", fmt_result(got_result)));
        end else begin
          want_result = expected_fill.pop_front();
          if (got_result !== want_result) begin
            flag_error($sformatf("result mismatch\n  exp %s\n  got %s",
                                 fmt_result(want_result), fmt_result(got_result)));
          end
        end
      end
      // input transfer, predicted right away
      if (pass_in.valid && pass_in.ready) begin
        expected_fill.push_back(dispense_pass(offered_pass));
        item_taken = 1'b1;
      end else begin
        item_taken = 1'b0;
      end
    end
  end

  // run limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk_i);
    $display("DONE: errors detected");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // register access
  // ---------------------------------------------------------------------------
  function automatic logic [31:0] reg_mask(input logic [CFG_IDX_W-1:0] idx);
    case (idx)
      CFG_VOLUME_STEP:                    return 32'h3FF;
      CFG_VOLUME_MAX, CFG_VOLUME_DEFAULT: return 32'hFFF;
      CFG_BOTTLE_PRESENT_MIN,
      CFG_LIGHT_BOTTLE_LIMIT,
      CFG_PLASTIC_ALLOWANCE:              return 32'hFF;
      default:                            return 32'h0;
    endcase
  endfunction

  // write one register with junk in the unused upper bits, then read it back
  task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] field);
    logic [31:0] wdata;
    logic [31:0] rdata;
    wdata = (field & reg_mask(idx)) | ($urandom & ~reg_mask(idx));
    // setup then access
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      CFG_VOLUME_STEP:        cfg_shadow.volume_step        = wdata[9:0];
      CFG_VOLUME_MAX:         cfg_shadow.volume_max         = wdata[11:0];
      CFG_VOLUME_DEFAULT:     cfg_shadow.volume_default     = wdata[11:0];
      CFG_BOTTLE_PRESENT_MIN: cfg_shadow.bottle_present_min = wdata[7:0];
      CFG_LIGHT_BOTTLE_LIMIT: cfg_shadow.light_bottle_limit = wdata[7:0];
      CFG_PLASTIC_ALLOWANCE:  cfg_shadow.plastic_allowance  = wdata[7:0];
      default: ;
    endcase
    // read back
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rdata !== (wdata & reg_mask(idx))) begin
      flag_error($sformatf("register %0d readback: exp %h got %h",
                           idx, wdata & reg_mask(idx), rdata));
    end
  endtask

  task automatic write_config(input cfg_t c);
    reg_write(CFG_VOLUME_STEP,        32'(c.volume_step));
    reg_write(CFG_VOLUME_MAX,         32'(c.volume_max));
    reg_write(CFG_VOLUME_DEFAULT,     32'(c.volume_default));
    reg_write(CFG_BOTTLE_PRESENT_MIN, 32'(c.bottle_present_min));
    reg_write(CFG_LIGHT_BOTTLE_LIMIT, 32'(c.light_bottle_limit));
    reg_write(CFG_PLASTIC_ALLOWANCE,  32'(c.plastic_allowance));
  endtask

  function automatic cfg_t pick_config();
    cfg_t c;
    c.volume_step        = 10'($urandom_range(200, 1));
    c.volume_max         = 12'($urandom_range(4095, 100));
    c.volume_default     = 12'($urandom_range(c.volume_max, 0));
    c.bottle_present_min = 8'($urandom_range(60, 1));
    c.light_bottle_limit = 8'($urandom_range(255, 0));
    c.plastic_allowance  = 8'($urandom_range(255, 0));
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // item generation
  // ---------------------------------------------------------------------------
  task automatic queue_pass(input bit wv, input int w, input bit sp, input bit mp,
                            input bit dv, input logic [4:0] day);
    pass_item_t it;
    it.weight_valid = wv;
    it.weight       = w[13:0];
    it.start_press  = sp;
    it.mode_press   = mp;
    it.date_valid   = dv;
    it.day_of_month = day;
    pass_queue.push_back(it);
    phase_items++;
  endtask

  // same, with the calendar mostly steady and now and then jumping
  task automatic queue_step(input bit wv, input int w, input bit sp, input bit mp);
    if ($urandom_range(39, 0) == 0) gen_day = 5'($urandom_range(31, 0));
    queue_pass(wv, w, sp, mp, $urandom_range(9, 0) != 0, gen_day);
  endtask

  // one bottle from volume choice to removal, with random content and a few faults
  task automatic queue_fill_cycle();
    int          lim;
    int          bpm;
    int          w0;
    int          w;
    int unsigned kind;
    int unsigned n;
    bpm = int'(cfg_shadow.bottle_present_min);
    lim = (cfg_shadow.volume_max > cfg_shadow.volume_default) ?
          int'(cfg_shadow.volume_max) : int'(cfg_shadow.volume_default);
    lim = lim + 300;

    // a few volume presses, then ok into ready
    n = $urandom_range(3, 0);
    repeat (n) queue_step(1'($urandom_range(1, 0)), $urandom_range(8191, 0), 1'b1, 1'b0);
    queue_step(1'b0, 0, 1'b0, 1'b1);

    // start: sometimes a full bottle or no bottle first
    kind = $urandom_range(99, 0);
    if (kind < 10) begin
      queue_step(1'b1, $urandom_range(8191, lim - 300), 1'b1, 1'($urandom_range(1, 0)));
    end else if (kind < 18 && bpm > 0) begin
      queue_step(1'b1, $urandom_range(bpm - 1, 0), 1'b1, 1'b0);
    end
    w0 = $urandom_range(bpm + 300, bpm);
    queue_step(1'b1, w0, 1'b1, $urandom_range(15, 0) == 0);

    // pouring, with pause and resume pairs and missing readings
    w = w0;
    n = $urandom_range(12, 1);
    repeat (n) begin
      w = w + $urandom_range(lim / 6 + 1, 0);
      if (w > 8191) w = 8191;
      if ($urandom_range(9, 0) == 0) begin
        queue_step(1'b1, w, 1'b1, 1'b0);
        queue_step(1'($urandom_range(1, 0)), w, 1'b1, 1'b0);
      end else begin
        queue_step($urandom_range(19, 0) != 0, w, 1'b0, $urandom_range(19, 0) == 0);
      end
    end
    // enough water to finish any target
    w = w0 + lim + $urandom_range(50, 0);
    if (w > 8191) w = 8191;
    queue_step(1'b1, w, 1'b0, 1'b0);

    // full: start is ignored
    n = $urandom_range(2, 0);
    repeat (n) queue_step(1'b1, w, 1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)));

    // lift the bottle, sometimes with a negative reading
    if ($urandom_range(5, 0) == 0) begin
      queue_step(1'b1, -int'($urandom_range(8192, 1)), 1'b0, 1'b0);
    end else begin
      queue_step(1'b1, (bpm > 0) ? $urandom_range(bpm - 1, 0) : 0, 1'b0, 1'b0);
    end
  endtask

  // waits until every offered item has its result, then lets the block settle
  task automatic wait_idle();
    while (pass_queue.size() != 0 || expected_fill.size() != 0 || pass_in.valid)
      @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    cfg_t c;
    rst_ni       = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    pass_in.valid        = 1'b0;
    pass_in.weight_valid = 1'b0;
    pass_in.weight       = '0;
    pass_in.start_press  = 1'b0;
    pass_in.mode_press   = 1'b0;
    pass_in.date_valid   = 1'b0;
    pass_in.day_of_month = '0;
    pass_out.ready       = 1'b0;
    item_taken   = 1'b0;
    error_count  = 0;
    cycle_count  = 0;
    tx_gap       = 0;
    rx_gap       = 0;
    rx_hold_cnt  = 0;
    rx_hold_req  = 1'b0;
    rx_hold_done = 1'b0;
    idle_en      = 1'b1;
    gen_day      = 5'd1;
    reset_model();

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed walk at reset settings: wv, weight, start, mode, date ok, day
    queue_pass(1'b0, 0,     1'b0, 1'b0, 1'b0, 5'd0);
    queue_pass(1'b1, -8192, 1'b0, 1'b0, 1'b1, 5'd0);   // day zero ignored, clamp
    queue_pass(1'b0, 0,     1'b1, 1'b0, 1'b0, 5'd0);   // volume plus one step
    queue_pass(1'b1, 8191,  1'b0, 1'b0, 1'b1, 5'd31);  // new day
    queue_pass(1'b0, 0,     1'b0, 1'b1, 1'b1, 5'd31);  // into ready
    queue_pass(1'b1, 5,     1'b1, 1'b0, 1'b1, 5'd31);  // no bottle
    queue_pass(1'b1, 8191,  1'b1, 1'b1, 1'b1, 5'd31);  // already full, ok held
    queue_pass(1'b0, 0,     1'b0, 1'b0, 1'b1, 5'd31);  // held ok toggles page
    queue_pass(1'b1, 20,    1'b1, 1'b0, 1'b1, 5'd31);  // light bottle, pour
    queue_pass(1'b1, 60,    1'b0, 1'b0, 1'b1, 5'd31);
    queue_pass(1'b0, 0,     1'b1, 1'b0, 1'b1, 5'd31);  // pause
    queue_pass(1'b1, 70,    1'b1, 1'b0, 1'b1, 5'd31);  // resume
    queue_pass(1'b0, 0,     1'b0, 1'b1, 1'b1, 5'd31);  // page toggle while pouring
    queue_pass(1'b1, 120,   1'b0, 1'b0, 1'b1, 5'd31);  // target reached
    queue_pass(1'b1, 200,   1'b1, 1'b0, 1'b1, 5'd31);  // start in full ignored
    queue_pass(1'b0, 0,     1'b0, 1'b1, 1'b0, 5'd31);
    queue_pass(1'b0, 0,     1'b0, 1'b0, 1'b1, 5'd5);   // day change clears total
    queue_pass(1'b1, -1,    1'b0, 1'b0, 1'b1, 5'd5);   // bottle removed
    wait_idle();

    // volume wrap with the widest step
    reg_write(CFG_VOLUME_STEP, 32'h3FF);
    queue_pass(1'b0, 0, 1'b1, 1'b0, 1'b1, 5'd5);
    queue_pass(1'b0, 0, 1'b1, 1'b0, 1'b1, 5'd5);
    queue_pass(1'b0, 0, 1'b0, 1'b1, 1'b1, 5'd5);
    queue_pass(1'b1, 300, 1'b1, 1'b0, 1'b1, 5'd5);     // heavy bottle, fixed allowance
    queue_pass(1'b1, 0, 1'b0, 1'b0, 1'b1, 5'd5);
    wait_idle();

    // random phases: typical, all zero, all ones, receiver hold-off, no idling
    for (int p = 0; p < 5; p++) begin
      case (p)
        1:       c = '0;
        2:       c = '1;
        default: c = pick_config();
      endcase
      write_config(c);
      idle_en     = (p != 4);
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        if ($urandom_range(4, 0) == 0) begin
          gen_day = 5'($urandom_range(31, 0));
          queue_step(1'($urandom_range(1, 0)), $urandom, 1'($urandom_range(1, 0)),
                     1'($urandom_range(1, 0)));
        end else begin
          queue_fill_cycle();
        end
      end
      // receiver stops while the sender keeps the channel busy
      if (p == 3) rx_hold_req = 1'b1;
      wait_idle();
    end

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
